>>> rtl/core/priority_acl_signal_filter_macros.svh
// Assertion helpers shared by the filter RTL.
`ifndef PRIORITY_ACL_SIGNAL_FILTER_MACROS_SVH
`define PRIORITY_ACL_SIGNAL_FILTER_MACROS_SVH

// Same-cycle implication.
`define PASF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PASF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/pasf_pkg.sv
package pasf_pkg;

  localparam int DEF_ENTITIES = 16;
  localparam int DEF_RULES    = 16;

  localparam int IN_W   = 64;
  localparam int OUT_W  = 48;
  localparam int RULE_W = 42;
  localparam int ADDR_W = 5;

  typedef enum logic [3:0] {
    MODE_CHECK         = 4'd0,
    MODE_ADD           = 4'd1,
    MODE_REMOVE        = 4'd2,
    MODE_CLEAR         = 4'd3,
    MODE_SET_DEFAULT   = 4'd4,
    MODE_SET_TRANSFORM = 4'd5,
    MODE_READ_STAT     = 4'd6,
    MODE_CLEAR_STATS   = 4'd7,
    MODE_RESET         = 4'd8
  } mode_t;

  localparam logic [1:0] VERDICT_DENY      = 2'd0;
  localparam logic [1:0] VERDICT_ALLOW     = 2'd1;
  localparam logic [1:0] VERDICT_LOG       = 2'd2;
  localparam logic [1:0] VERDICT_TRANSFORM = 2'd3;

  localparam logic [2:0] STAT_CHECKED     = 3'd0;
  localparam logic [2:0] STAT_ALLOWED     = 3'd1;
  localparam logic [2:0] STAT_DENIED      = 3'd2;
  localparam logic [2:0] STAT_LOGGED      = 3'd3;
  localparam logic [2:0] STAT_DEFAULT     = 3'd4;
  localparam logic [2:0] STAT_TRANSFORMED = 3'd5;
  localparam int         STAT_NUM         = 6;

  localparam logic [2:0] REG_SRC_ANY      = 3'd0;
  localparam logic [2:0] REG_SRC_LOCAL    = 3'd1;
  localparam logic [2:0] REG_SRC_EXTERNAL = 3'd2;
  localparam logic [2:0] REG_SIG_ANY      = 3'd3;
  localparam logic [2:0] REG_SIG_SYSTEM   = 3'd4;
  localparam logic [2:0] REG_SIG_USER     = 3'd5;

  localparam logic [15:0] RST_ANY      = 16'hFFFF;
  localparam logic [15:0] RST_LOCAL    = 16'hFFFE;
  localparam logic [15:0] RST_EXTERNAL = 16'hFFFD;

  localparam logic [15:0] SIG_SYS_LO  = 16'h0001;
  localparam logic [15:0] SIG_SYS_HI  = 16'h00FF;
  localparam logic [15:0] SIG_USER_LO = 16'h0100;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_KRD, ST_KCMP, ST_ENT, ST_IRD, ST_IWAIT, ST_DISP,
    ST_RRD, ST_RCMP, ST_SRD, ST_SWR, ST_INS, ST_IWR, ST_CFIN, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic key_rd;
    logic key_cmp;
    logic alloc;
    logic info_rd;
    logic info_ld;
    logic scan_init;
    logic full;
    logic rule_rd;
    logic idx_inc;
    logic chk_take;
    logic pos_take;
    logic rem_cmp;
    logic rem_end;
    logic shift_rd;
    logic shift_wr;
    logic ins;
    logic upd;
    logic info_wr;
    logic chk_fin;
    logic done_ld;
  } cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       ready;
    logic       key_more;
    logic       key_hit;
    logic       found;
    logic       table_full;
    logic       count_full;
    logic       rule_more;
    logic       chk_hit;
    logic       pos_hit;
    logic       shift_more;
    logic       out_free;
  } stat_t;

  function automatic logic src_match(input logic [15:0] pat, input logic [15:0] v,
                                     input logic [15:0] any, input logic [15:0] loc,
                                     input logic [15:0] ext, input logic [8:0] ents);
    logic r;
    if (pat == any) r = 1'b1;
    else if (pat == loc) r = (v >= 16'd1) && (v <= {7'd0, ents});
    else if (pat == ext) r = (v == 16'd0) || (v > {7'd0, ents});
    else r = (pat == v);
    return r;
  endfunction

  function automatic logic sig_match(input logic [15:0] pat, input logic [15:0] v,
                                     input logic [15:0] any, input logic [15:0] sys,
                                     input logic [15:0] usr);
    logic r;
    if (pat == any) r = 1'b1;
    else if (pat == sys) r = (v >= SIG_SYS_LO) && (v <= SIG_SYS_HI);
    else if (pat == usr) r = (v >= SIG_USER_LO);
    else r = (pat == v);
    return r;
  endfunction

endpackage

>>> rtl/core/pasf_ram.sv
module pasf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pasf_ctrl.sv
module pasf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  pasf_pkg::stat_t stat,
  output pasf_pkg::cmd_t  cmd
);
  import pasf_pkg::*;

  state_t state, state_next;
  logic   needs_slot;

  assign needs_slot = stat.mode inside {MODE_ADD, MODE_CLEAR, MODE_SET_DEFAULT,
                                        MODE_SET_TRANSFORM};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_PREP;
      ST_PREP:  state_next = ST_KRD;
      ST_KRD:   state_next = stat.key_more ? ST_KCMP : ST_ENT;
      ST_KCMP:  state_next = stat.key_hit ? ST_ENT : ST_KRD;
      ST_ENT: begin
        if (stat.found) state_next = ST_IRD;
        else if (needs_slot && stat.table_full) state_next = ST_DONE;
        else state_next = ST_DISP;
      end
      ST_IRD:   state_next = ST_IWAIT;
      ST_IWAIT: state_next = ST_DISP;
      ST_DISP: begin
        case (stat.mode)
          MODE_CHECK:  state_next = (stat.ready && stat.found) ? ST_RRD : ST_CFIN;
          MODE_ADD:    state_next = stat.count_full ? ST_DONE : ST_RRD;
          MODE_REMOVE: state_next = stat.found ? ST_RRD : ST_DONE;
          MODE_CLEAR, MODE_SET_DEFAULT, MODE_SET_TRANSFORM: state_next = ST_IWR;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_RRD: begin
        if (stat.rule_more) state_next = ST_RCMP;
        else if (stat.mode == MODE_CHECK) state_next = ST_CFIN;
        else if (stat.mode == MODE_ADD) state_next = ST_SRD;
        else state_next = ST_IWR;
      end
      ST_RCMP: begin
        if (stat.mode == MODE_CHECK && stat.chk_hit) state_next = ST_CFIN;
        else if (stat.mode == MODE_ADD && stat.pos_hit) state_next = ST_SRD;
        else state_next = ST_RRD;
      end
      ST_SRD:   state_next = stat.shift_more ? ST_SWR : ST_INS;
      ST_SWR:   state_next = ST_SRD;
      ST_INS:   state_next = ST_IWR;
      ST_IWR:   state_next = ST_DONE;
      ST_CFIN:  state_next = ST_DONE;
      ST_DONE:  if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_PREP:  cmd.prep = 1'b1;
      ST_KRD:   cmd.key_rd = stat.key_more;
      ST_KCMP:  cmd.key_cmp = 1'b1;
      ST_ENT: begin
        if (stat.found) cmd.info_rd = 1'b1;
        else if (needs_slot && stat.table_full) cmd.full = 1'b1;
        else if (needs_slot) cmd.alloc = 1'b1;
      end
      ST_IWAIT: cmd.info_ld = 1'b1;
      ST_DISP: begin
        cmd.scan_init = 1'b1;
        case (stat.mode)
          MODE_ADD: cmd.full = stat.count_full;
          MODE_CLEAR, MODE_SET_DEFAULT, MODE_SET_TRANSFORM: cmd.upd = 1'b1;
          default: ;
        endcase
      end
      ST_RRD: begin
        cmd.rule_rd = stat.rule_more;
        cmd.rem_end = !stat.rule_more && (stat.mode == MODE_REMOVE);
      end
      ST_RCMP: begin
        case (stat.mode)
          MODE_CHECK: begin
            cmd.chk_take = stat.chk_hit;
            cmd.idx_inc  = !stat.chk_hit;
          end
          MODE_ADD: begin
            cmd.pos_take = stat.pos_hit;
            cmd.idx_inc  = !stat.pos_hit;
          end
          default: cmd.rem_cmp = 1'b1;
        endcase
      end
      ST_SRD:   cmd.shift_rd = stat.shift_more;
      ST_SWR:   cmd.shift_wr = 1'b1;
      ST_INS:   cmd.ins = 1'b1;
      ST_IWR:   cmd.info_wr = 1'b1;
      ST_CFIN:  cmd.chk_fin = 1'b1;
      ST_DONE:  cmd.done_ld = stat.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/pasf_dp.sv
module pasf_dp #(
  parameter int ENTITIES = pasf_pkg::DEF_ENTITIES,
  parameter int RULES    = pasf_pkg::DEF_RULES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pasf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  input  logic [pasf_pkg::IN_W-1:0]   s_tdata,
  input  logic [3:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pasf_pkg::OUT_W-1:0]  m_tdata,
  input  pasf_pkg::cmd_t              cmd,
  output pasf_pkg::stat_t             stat
);
  import pasf_pkg::*;

  localparam int EW     = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
  localparam int UW     = $clog2(ENTITIES + 1);
  localparam int RW     = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CW     = $clog2(RULES + 1);
  localparam int INFO_W = CW + 2;

  // configuration registers
  logic [15:0] src_any, src_loc, src_ext, sig_any, sig_sys, sig_usr;
  logic [2:0]  reg_idx;

  // latched request
  logic [3:0]  mode_r;
  logic [15:0] key_r, src_r, sig_r;
  logic [7:0]  prio_r;
  logic [1:0]  act_r;
  logic        pol_r, ten_r, tok_r;
  logic [2:0]  sidx_r;

  // table state
  logic          ready;
  logic [UW-1:0] used;
  logic [31:0]   stats [STAT_NUM];

  // work registers
  logic [UW-1:0] kidx;
  logic [EW-1:0] slot;
  logic          found, hit;
  logic [CW-1:0] count, idx, wptr, jpos, wptr_m1;
  logic          fdeny, ftrans;

  // result fields
  logic        status_r, passes_r, usedef_r;
  logic [1:0]  verdict_r;
  logic [4:0]  removed_r;
  logic [31:0] sval_r;

  logic [15:0]         key_rdata;
  logic [INFO_W-1:0]   info_rdata, info_wdata;
  logic                info_we;
  logic [EW-1:0]       info_waddr;
  logic [RULE_W-1:0]   rule_rdata, rule_wdata;
  logic                rule_we;
  logic [EW+RW-1:0]    rule_waddr, rule_raddr;
  logic [15:0]         rd_src, rd_sig;
  logic [7:0]          rd_prio;
  logic [1:0]          rd_act;
  logic                rem_keep, wipe;
  logic [1:0]          fin_verdict;

  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_any <= RST_ANY;
      src_loc <= RST_LOCAL;
      src_ext <= RST_EXTERNAL;
      sig_any <= RST_ANY;
      sig_sys <= RST_LOCAL;
      sig_usr <= RST_EXTERNAL;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SRC_ANY:      src_any <= pwdata[15:0];
        REG_SRC_LOCAL:    src_loc <= pwdata[15:0];
        REG_SRC_EXTERNAL: src_ext <= pwdata[15:0];
        REG_SIG_ANY:      sig_any <= pwdata[15:0];
        REG_SIG_SYSTEM:   sig_sys <= pwdata[15:0];
        REG_SIG_USER:     sig_usr <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_ANY:      prdata = {16'd0, src_any};
      REG_SRC_LOCAL:    prdata = {16'd0, src_loc};
      REG_SRC_EXTERNAL: prdata = {16'd0, src_ext};
      REG_SIG_ANY:      prdata = {16'd0, sig_any};
      REG_SIG_SYSTEM:   prdata = {16'd0, sig_sys};
      REG_SIG_USER:     prdata = {16'd0, sig_usr};
      default:          prdata = 32'd0;
    endcase
  end

  assign rd_src  = rule_rdata[15:0];
  assign rd_sig  = rule_rdata[31:16];
  assign rd_prio = rule_rdata[39:32];
  assign rd_act  = rule_rdata[41:40];
  assign wptr_m1 = wptr - CW'(1);

  // remove pattern: the "any" code is a wildcard, everything else compares raw
  assign rem_keep = !(((src_r == src_any) || (rd_src == src_r)) &&
                      ((sig_r == sig_any) || (rd_sig == sig_r)));

  assign wipe = (mode_r == MODE_RESET) ||
                (!ready && (mode_r inside {MODE_ADD, MODE_CLEAR, MODE_SET_DEFAULT}));

  always_comb begin
    if (!ready) fin_verdict = VERDICT_ALLOW;
    else if (!found || !hit) fin_verdict = (found && fdeny) ? VERDICT_DENY : VERDICT_ALLOW;
    else fin_verdict = verdict_r;
  end

  always_comb begin
    stat.mode       = mode_r;
    stat.ready      = ready;
    stat.key_more   = kidx < used;
    stat.key_hit    = key_rdata == key_r;
    stat.found      = found;
    stat.table_full = used == UW'(ENTITIES);
    stat.count_full = count >= CW'(RULES);
    stat.rule_more  = idx < count;
    stat.chk_hit    = src_match(rd_src, src_r, src_any, src_loc, src_ext, 9'(ENTITIES)) &&
                      sig_match(rd_sig, sig_r, sig_any, sig_sys, sig_usr);
    stat.pos_hit    = prio_r < rd_prio;
    stat.shift_more = wptr > jpos;
    stat.out_free   = !m_tvalid || m_tready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ready    <= 1'b0;
      used     <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < STAT_NUM; i++) stats[i] <= 32'd0;
    end else begin
      if (cmd.prep) begin
        if (wipe) begin
          used <= '0;
          for (int i = 0; i < STAT_NUM; i++) stats[i] <= 32'd0;
          if (mode_r != MODE_RESET) ready <= 1'b1;
        end
        if (mode_r == MODE_CLEAR_STATS) begin
          for (int i = 0; i < STAT_NUM; i++) stats[i] <= 32'd0;
        end
      end
      if (cmd.alloc) used <= used + UW'(1);
      if (cmd.chk_fin) begin
        if (!ready) begin
          stats[STAT_ALLOWED] <= stats[STAT_ALLOWED] + 32'd1;
        end else begin
          stats[STAT_CHECKED] <= stats[STAT_CHECKED] + 32'd1;
          if (!found || !hit) stats[STAT_DEFAULT] <= stats[STAT_DEFAULT] + 32'd1;
          if (fin_verdict == VERDICT_TRANSFORM && ftrans && !tok_r) begin
            stats[STAT_DENIED] <= stats[STAT_DENIED] + 32'd1;
          end else if (fin_verdict == VERDICT_DENY) begin
            stats[STAT_DENIED] <= stats[STAT_DENIED] + 32'd1;
          end else begin
            stats[STAT_ALLOWED] <= stats[STAT_ALLOWED] + 32'd1;
          end
          if (fin_verdict == VERDICT_TRANSFORM && ftrans && tok_r) begin
            stats[STAT_TRANSFORMED] <= stats[STAT_TRANSFORMED] + 32'd1;
          end
          if (fin_verdict == VERDICT_LOG) stats[STAT_LOGGED] <= stats[STAT_LOGGED] + 32'd1;
        end
      end
      if (cmd.done_ld) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= s_tuser;
      key_r     <= s_tdata[15:0];
      src_r     <= s_tdata[31:16];
      sig_r     <= s_tdata[47:32];
      prio_r    <= s_tdata[55:48];
      act_r     <= s_tdata[57:56];
      pol_r     <= s_tdata[58];
      ten_r     <= s_tdata[59];
      tok_r     <= s_tdata[60];
      sidx_r    <= s_tdata[63:61];
      status_r  <= 1'b0;
      verdict_r <= VERDICT_DENY;
      passes_r  <= 1'b0;
      usedef_r  <= 1'b0;
      removed_r <= 5'd0;
      sval_r    <= 32'd0;
      hit       <= 1'b0;
      found     <= 1'b0;
      kidx      <= '0;
    end
    if (cmd.prep && mode_r == MODE_READ_STAT && sidx_r <= STAT_TRANSFORMED) begin
      sval_r <= stats[sidx_r];
    end
    if (cmd.key_cmp) begin
      if (stat.key_hit) begin
        found <= 1'b1;
        slot  <= kidx[EW-1:0];
      end else begin
        kidx <= kidx + UW'(1);
      end
    end
    if (cmd.alloc) begin
      found  <= 1'b1;
      slot   <= used[EW-1:0];
      count  <= '0;
      fdeny  <= 1'b0;
      ftrans <= 1'b0;
    end
    if (cmd.info_ld) {ftrans, fdeny, count} <= info_rdata;
    if (cmd.full) status_r <= 1'b1;
    if (cmd.scan_init) begin
      idx  <= '0;
      jpos <= count;
      wptr <= (mode_r == MODE_ADD) ? count : '0;
    end
    if (cmd.idx_inc) idx <= idx + CW'(1);
    if (cmd.chk_take) begin
      hit       <= 1'b1;
      verdict_r <= rd_act;
    end
    if (cmd.pos_take) jpos <= idx;
    if (cmd.rem_cmp) begin
      idx <= idx + CW'(1);
      if (rem_keep) wptr <= wptr + CW'(1);
    end
    if (cmd.rem_end) begin
      removed_r <= 5'(count - wptr);
      count     <= wptr;
    end
    if (cmd.shift_wr) wptr <= wptr_m1;
    if (cmd.ins) count <= count + CW'(1);
    if (cmd.upd) begin
      case (mode_r)
        MODE_CLEAR:         count  <= '0;
        MODE_SET_DEFAULT:   fdeny  <= pol_r;
        MODE_SET_TRANSFORM: ftrans <= ten_r;
        default: ;
      endcase
    end
    if (cmd.chk_fin) begin
      verdict_r <= fin_verdict;
      usedef_r  <= !ready || !found || !hit;
      if (fin_verdict == VERDICT_TRANSFORM && ftrans && ready) passes_r <= tok_r;
      else passes_r <= fin_verdict != VERDICT_DENY;
    end
    if (cmd.done_ld) begin
      m_tdata <= {1'b0, (found ? 5'(count) : 5'd0), sval_r, removed_r, usedef_r,
                  passes_r, verdict_r, status_r};
    end
  end

  // memories: entity keys, per-entity info, rule lists
  assign info_we    = cmd.alloc || cmd.info_wr;
  assign info_waddr = cmd.alloc ? used[EW-1:0] : slot;
  assign info_wdata = cmd.alloc ? '0 : {ftrans, fdeny, count};

  pasf_ram #(.WIDTH(16), .DEPTH(2 ** EW)) u_key_ram (
    .clk   (clk),
    .we    (cmd.alloc),
    .waddr (used[EW-1:0]),
    .wdata (key_r),
    .re    (cmd.key_rd),
    .raddr (kidx[EW-1:0]),
    .rdata (key_rdata)
  );

  pasf_ram #(.WIDTH(INFO_W), .DEPTH(2 ** EW)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .re    (cmd.info_rd),
    .raddr (slot),
    .rdata (info_rdata)
  );

  assign rule_raddr = cmd.shift_rd ? {slot, wptr_m1[RW-1:0]} : {slot, idx[RW-1:0]};
  assign rule_we    = cmd.shift_wr || cmd.ins || (cmd.rem_cmp && rem_keep);
  assign rule_waddr = cmd.ins ? {slot, jpos[RW-1:0]} : {slot, wptr[RW-1:0]};
  assign rule_wdata = cmd.ins ? {act_r, prio_r, sig_r, src_r} : rule_rdata;

  pasf_ram #(.WIDTH(RULE_W), .DEPTH(2 ** (EW + RW))) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_waddr),
    .wdata (rule_wdata),
    .re    (cmd.rule_rd || cmd.shift_rd),
    .raddr (rule_raddr),
    .rdata (rule_rdata)
  );

endmodule

>>> rtl/core/priority_acl_signal_filter.sv
// First-match signal filter with per-destination rule lists. One request is in
// flight at a time; the result sits in an output register, so the next request is
// taken while it waits. Each request compares entity slots one by one (a key
// memory read for each), then reads the info word when the slot exists. The
// per-mode work follows: a check reads the rule memory for each rule scanned, then
// finishes; an add scans the rules for its position, then shifts the rules behind
// it and inserts; a remove reads every rule held; the other modes do no rule work.
// A stalled result holds the next request back. No clearing pass: slot and rule
// counts mark what is valid, so the block is usable right after reset.
module priority_acl_signal_filter #(
  parameter int ENTITIES = pasf_pkg::DEF_ENTITIES,
  parameter int RULES    = pasf_pkg::DEF_RULES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pasf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // entity_key, source_code, signal_code, rule_priority, rule_verdict,
  // policy_deny, transform_enable, transform_allows, stat_index
  input  logic [pasf_pkg::IN_W-1:0]   s_tdata,
  // mode
  input  logic [3:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status, verdict, passes, used_default, removed_count, stat_value,
  // rules_held, zero pad
  output logic [pasf_pkg::OUT_W-1:0]  m_tdata
);
  import pasf_pkg::*;
  `include "priority_acl_signal_filter_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  pasf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pasf_dp #(.ENTITIES(ENTITIES), .RULES(RULES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  `PASF_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "second request taken while busy")
  `PASF_ASSERT_IMPL(a_done_free, clk, rst, cmd.done_ld, stat.out_free, "result loaded over pending result")
  `PASF_ASSERT_IMPL(a_rule_wr_one, clk, rst, 1'b1, $onehot0({cmd.shift_wr, cmd.ins, cmd.rem_cmp}), "rule write conflict")

endmodule
